FILE: rtl/lfu_pkg.sv
`default_nettype none

package lfu_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int COUNT_BITS  = 16;

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int RANK_W = IDX_W;
  localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
  localparam int SCAN_W = $clog2(MAX_ENTRIES + 2);
  localparam int CAP_W  = 5;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int REG_W  = ADDR_W - 2;

  localparam logic [CAP_W-1:0]      CAP_RESET = 5'd16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  localparam logic [REG_W-1:0] REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic                  mode;
    logic [KEY_BITS-1:0]   req_key;
    logic [VALUE_BITS-1:0] req_value;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic bump;
    logic evict;
    logic insert;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic go_bump;
    logic go_evict;
    logic go_insert;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

FILE: rtl/lfu_cfg_regs.sv
`default_nettype none

module lfu_cfg_regs import lfu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [CAP_W-1:0]  capacity
);

  logic [CAP_W-1:0] capacity_r;
  logic [CAP_W-1:0] capacity_nxt;
  logic             sel_cap;

  assign sel_cap = (paddr[ADDR_W-1:2] == REG_CAPACITY);
  assign pready  = 1'b1;

  always_comb begin
    capacity_nxt = capacity_r;
    if (psel && penable && pwrite && pready && sel_cap) begin
      capacity_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  assign prdata   = sel_cap ? DATA_W'(capacity_r) : '0;
  assign capacity = capacity_r;

endmodule

`default_nettype wire

FILE: rtl/lfu_ctrl.sv
`default_nettype none

module lfu_ctrl import lfu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_BUMP   = 6'b000100,
    ST_EVICT  = 6'b001000,
    ST_INSERT = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.scan_done) begin
          cmd.scan = 1'b1;
        end else if (sts.go_bump) begin
          state_nxt = ST_BUMP;
        end else if (sts.go_evict) begin
          state_nxt = ST_EVICT;
        end else if (sts.go_insert) begin
          state_nxt = ST_INSERT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_BUMP: begin
        cmd.bump  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/lfu_datapath.sv
`default_nettype none

module lfu_datapath import lfu_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ctl_cmd_t         cmd,
  output ctl_sts_t              sts,
  input  wire req_t             in_word,
  input  wire logic [CAP_W-1:0] capacity,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rsp_t                  out_word
);

  // entry store
  logic [KEY_BITS-1:0]   key_mem [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0] valid_r;
  logic [MAX_ENTRIES-1:0] valid_nxt;
  logic [RANK_W-1:0]      rank_r   [MAX_ENTRIES];
  logic [RANK_W-1:0]      rank_nxt [MAX_ENTRIES];
  logic [FILL_W-1:0]      fill_r;
  logic [FILL_W-1:0]      fill_nxt;

  req_t req_r;

  // scan pipeline
  logic [SCAN_W-1:0]     scan_idx_r;
  logic [SCAN_W-1:0]     scan_idx_nxt;
  logic                  cmp_en_r;
  logic                  cmp_en_nxt;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic [KEY_BITS-1:0]   key_rd_r;
  logic [VALUE_BITS-1:0] val_rd_r;
  logic [COUNT_BITS-1:0] cnt_rd_r;

  // scan results
  logic                  found_r;
  logic [IDX_W-1:0]      hit_idx_r;
  logic [VALUE_BITS-1:0] hit_val_r;
  logic [COUNT_BITS-1:0] hit_cnt_r;
  logic [RANK_W-1:0]     hit_rank_r;
  logic                  have_victim_r;
  logic [IDX_W-1:0]      victim_r;
  logic [COUNT_BITS-1:0] best_cnt_r;
  logic [RANK_W-1:0]     best_rank_r;
  logic [KEY_BITS-1:0]   victim_key_r;
  logic                  have_free_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic                  ev_r;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  rsp_t                  out_word_r;

  logic                  cmp_valid;
  logic [RANK_W-1:0]     cmp_rank;
  logic                  better;
  logic [FILL_W-1:0]     cap_eff;
  logic                  is_put;
  logic                  cap_zero;
  logic                  new_put;
  logic [IDX_W-1:0]      slot;
  logic [IDX_W-1:0]      wr_idx;
  logic [COUNT_BITS-1:0] cnt_wr;

  assign cmp_valid = valid_r[cmp_idx_r];
  assign cmp_rank  = rank_r[cmp_idx_r];
  assign better    = !have_victim_r || (cnt_rd_r < best_cnt_r) ||
                     ((cnt_rd_r == best_cnt_r) && (cmp_rank > best_rank_r));

  assign cap_eff  = (capacity > CAP_W'(MAX_ENTRIES)) ? FILL_W'(MAX_ENTRIES)
                                                     : FILL_W'(capacity);
  assign is_put   = (req_r.mode == MODE_PUT);
  assign cap_zero = (cap_eff == '0);
  assign new_put  = is_put && !cap_zero && !found_r;

  assign sts.scan_done = (scan_idx_r == SCAN_W'(MAX_ENTRIES + 1));
  assign sts.go_bump   = found_r && (!is_put || !cap_zero);
  assign sts.go_evict  = new_put && (fill_r >= cap_eff) && have_victim_r;
  assign sts.go_insert = new_put && !sts.go_evict && have_free_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  // lowest free slot once the victim has left
  assign slot   = (ev_r && !(have_free_r && (free_idx_r < victim_r))) ? victim_r
                                                                      : free_idx_r;
  assign wr_idx = cmd.insert ? slot : hit_idx_r;
  assign cnt_wr = cmd.insert ? COUNT_ONE :
                  (hit_cnt_r == COUNT_MAX) ? hit_cnt_r : hit_cnt_r + COUNT_ONE;

  always_comb begin
    scan_idx_nxt = scan_idx_r;
    cmp_en_nxt   = 1'b0;
    if (cmd.start) begin
      scan_idx_nxt = '0;
    end else if (cmd.scan) begin
      scan_idx_nxt = scan_idx_r + 1'b1;
      cmp_en_nxt   = (scan_idx_r < SCAN_W'(MAX_ENTRIES));
    end
  end

  // recency row: every cell updates against a broadcast rank (bump, evict) or slot (insert)
  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    fill_nxt  = fill_r;
    if (cmd.bump) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IDX_W'(i) == hit_idx_r) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
    end
    if (cmd.evict) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IDX_W'(i) == victim_r) begin
          valid_nxt[i] = 1'b0;
        end else if (valid_r[i] && (rank_r[i] > best_rank_r)) begin
          rank_nxt[i] = rank_r[i] - 1'b1;
        end
      end
      fill_nxt = fill_r - 1'b1;
    end
    if (cmd.insert) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          valid_nxt[i] = 1'b1;
          rank_nxt[i]  = '0;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      fill_r      <= '0;
      scan_idx_r  <= '0;
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      fill_r      <= fill_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_en_r    <= cmp_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      key_mem[slot] <= req_r.req_key;
    end
    if (cmd.insert || (cmd.bump && is_put)) begin
      val_mem[wr_idx] <= req_r.req_value;
    end
    if (cmd.insert || cmd.bump) begin
      cnt_mem[wr_idx] <= cnt_wr;
    end
    key_rd_r  <= key_mem[scan_idx_r[IDX_W-1:0]];
    val_rd_r  <= val_mem[scan_idx_r[IDX_W-1:0]];
    cnt_rd_r  <= cnt_mem[scan_idx_r[IDX_W-1:0]];
    cmp_idx_r <= scan_idx_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r       <= 1'b0;
      have_victim_r <= 1'b0;
      have_free_r   <= 1'b0;
      ev_r          <= 1'b0;
    end else if (cmd.start) begin
      found_r       <= 1'b0;
      have_victim_r <= 1'b0;
      have_free_r   <= 1'b0;
      ev_r          <= 1'b0;
    end else begin
      if (cmp_en_r && cmp_valid && (key_rd_r == req_r.req_key) && !found_r) begin
        found_r <= 1'b1;
      end
      if (cmp_en_r && cmp_valid && better) begin
        have_victim_r <= 1'b1;
      end
      if (cmp_en_r && !cmp_valid && !have_free_r) begin
        have_free_r <= 1'b1;
      end
      if (cmd.evict) begin
        ev_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r <= in_word;
    end
    if (cmp_en_r && cmp_valid && (key_rd_r == req_r.req_key) && !found_r) begin
      hit_idx_r  <= cmp_idx_r;
      hit_val_r  <= val_rd_r;
      hit_cnt_r  <= cnt_rd_r;
      hit_rank_r <= cmp_rank;
    end
    if (cmp_en_r && cmp_valid && better) begin
      victim_r     <= cmp_idx_r;
      best_cnt_r   <= cnt_rd_r;
      best_rank_r  <= cmp_rank;
      victim_key_r <= key_rd_r;
    end
    if (cmp_en_r && !cmp_valid && !have_free_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (cmd.load) begin
      out_word_r.found       <= found_r;
      out_word_r.read_value  <= (found_r && !is_put) ? hit_val_r : '0;
      out_word_r.evicted     <= ev_r;
      out_word_r.evicted_key <= ev_r ? victim_key_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

FILE: rtl/lfu_cache_policy_core.sv
// order: after the scan a get miss or ignored put goes to done, a hit to bump, a plain
// insert to insert, an evict and insert to evict then insert; done registers the result
// word once the output is free, and no new request is taken until then; the scan reads
// one slot of the key, value and count memories per cycle across all 16 entries
// reset: synchronous active-low rst_n clears the valid marks and fill count, sets
// capacity to 16 and empties the output register; no clearing pass is needed
`default_nettype none

module lfu_cache_policy_core import lfu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire req_t              in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rsp_t                   out_word,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  ctl_cmd_t         cmd;
  ctl_sts_t         sts;
  logic [CAP_W-1:0] capacity;

  lfu_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfu_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .capacity  (capacity),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

FILE: rtl/lfu_checker.sv
`default_nettype none

module lfu_checker import lfu_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire rsp_t              out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  a_miss_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.found |-> out_word.read_value == '0)
    else $error("value returned on a miss");

  a_evict_only_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.evicted |-> !out_word.found)
    else $error("eviction reported for a key that was present");

  a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.evicted |-> out_word.evicted_key == '0)
    else $error("evicted key set without an eviction");

endmodule

bind lfu_cache_policy_core lfu_checker u_chk (.*);

`default_nettype wire
